/* rtl/core/fixed_string_line_matcher_macros.svh */
// Assertion macros for the fixed-string line matcher checker.
// Needs clk and rst in the scope where a macro is used.
`ifndef FIXED_STRING_LINE_MATCHER_MACROS_SVH
`define FIXED_STRING_LINE_MATCHER_MACROS_SVH

// Same-cycle implication, reset disables.
`define FSLM_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset disables.
`define FSLM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/fslm_pkg.sv */
// Package for the fixed-string line matcher: sizes, codes, structs, fold helper.
// No dependencies.
`timescale 1ns / 1ps

package fslm_pkg;

  localparam int MAX_PATTERN  = 16;
  localparam int PAT_REG_BYTES = 16;
  localparam int LEN_CAP      = (MAX_PATTERN < PAT_REG_BYTES) ? MAX_PATTERN : PAT_REG_BYTES;
  localparam int WIN_DEPTH    = MAX_PATTERN;
  localparam int FILL_W       = $clog2(MAX_PATTERN + 1);
  localparam int PAT_IDX_W    = $clog2(PAT_REG_BYTES);
  localparam int LEN_W        = 5;
  localparam int CFG_IDX_W    = 3;

  localparam logic [7:0]  NEWLINE     = 8'd10;
  localparam logic [7:0]  FOLD_OFFSET = 8'd32;
  localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
  localparam logic [7:0]  CHAR_UPPER_Z = 8'h5a;
  localparam logic [31:0] CNT_MAX     = 32'hffff_ffff;

  typedef enum logic [1:0] {
    KIND_VERDICT = 2'd0,
    KIND_FILE    = 2'd1,
    KIND_COUNT   = 2'd2,
    KIND_FINAL   = 2'd3
  } fslm_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_PATTERN_LEN  = 3'd2,
    REG_IGNORE_CASE  = 3'd3,
    REG_INVERT_SENSE = 3'd4,
    REG_COUNT_MODE   = 3'd5,
    REG_FILE_MODE    = 3'd6
  } fslm_reg_t;

  typedef struct packed {
    logic [8*PAT_REG_BYTES-1:0] pattern;
    logic [LEN_W-1:0]           len;
    logic                       ignore_case;
  } fslm_pat_t;

  typedef struct packed {
    logic       shift;
    logic       restart;
    logic [7:0] data;
  } fslm_win_ctrl_t;

  typedef struct packed {
    logic hit;
    logic empty_pat;
  } fslm_win_stat_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
    if (en && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      return b + FOLD_OFFSET;
    end
    return b;
  endfunction

endpackage

/* rtl/core/fslm_text_if.sv */
// Input channel interface: one text request per byte or end of input.
// Depends on nothing.
`timescale 1ns / 1ps

interface fslm_text_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;

  modport source (output valid, func, data_byte, input ready);
  modport sink   (input valid, func, data_byte, output ready);
endinterface

/* rtl/core/fslm_result_if.sv */
// Result channel interface: verdicts, reports and final status.
// Depends on nothing.
`timescale 1ns / 1ps

interface fslm_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        selected;
  logic [31:0] line_number;
  logic [31:0] sel_count;
  logic        status;
  logic        last;

  modport source (output valid, kind, selected, line_number, sel_count, status, last,
                  input ready);
  modport sink   (input valid, kind, selected, line_number, sel_count, status, last,
                  output ready);
endinterface

/* rtl/core/fslm_cfg_if.sv */
// Configuration write channel interface: register index and write data.
// Depends on fslm_pkg.
`timescale 1ns / 1ps

interface fslm_cfg_if;
  import fslm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [63:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/fixed_string_line_matcher.sv */
// Fixed-string line matcher: text in, a line window compare against a pattern of up to
// 16 bytes, per-line verdicts, a count or one-shot file-matched report and a final status out.
// An ordinary byte never waits on the result side, so ordinary bytes stream at one byte
// per cycle. A newline or end of input yields up to two results; they leave the result
// register one per cycle while the result side is ready, and the next item with results
// waits until that register has drained. A request is registered in the input stage,
// its results in the result register. Registers are to be written only while the block
// is idle; the block does not enforce this. A pattern change takes effect on the next byte.
// Depends on fslm_pkg, fslm_text_if, fslm_result_if, fslm_cfg_if, fslm_window.
`timescale 1ns / 1ps

module fixed_string_line_matcher (
  input logic          clk,
  input logic          rst,
  fslm_text_if.sink    text,
  fslm_result_if.source result,
  fslm_cfg_if.sink     cfg
);
  import fslm_pkg::*;

  // registers
  logic [63:0]      pattern_low;
  logic [63:0]      pattern_high;
  logic [LEN_W-1:0] pattern_len;
  logic             ignore_case;
  logic             invert_sense;
  logic             count_mode;
  logic             file_mode;

  // input stage
  logic       s1_valid;
  logic       s1_func;
  logic [7:0] s1_byte;

  // stream state
  logic        line_hit;
  logic        line_pending;
  logic [31:0] line_index;
  logic [31:0] sel_total;
  logic        stopped;

  // result bundle
  logic        b_line;
  logic        b_line_file;
  logic        b_sel;
  logic [31:0] b_line_num;
  logic        b_count;
  logic        b_final;
  logic [31:0] b_total;

  fslm_pat_t      pat;
  fslm_win_ctrl_t wctrl;
  fslm_win_stat_t wstat;

  logic        take;
  logic        b_line_left, b_count_left, b_final_left;
  logic        bund_free;
  logic        adv;
  logic        is_nl;
  logic        closing;
  logic        sel;
  logic [31:0] total_next;
  logic        n_line, n_line_file, n_count, n_final;
  logic        any_res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low  <= '0;
      pattern_high <= '0;
      pattern_len  <= '0;
      ignore_case  <= 1'b0;
      invert_sense <= 1'b0;
      count_mode   <= 1'b0;
      file_mode    <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PATTERN_LOW:  pattern_low  <= cfg.data;
        REG_PATTERN_HIGH: pattern_high <= cfg.data;
        REG_PATTERN_LEN:  pattern_len  <= cfg.data[LEN_W-1:0];
        REG_IGNORE_CASE:  ignore_case  <= cfg.data[0];
        REG_INVERT_SENSE: invert_sense <= cfg.data[0];
        REG_COUNT_MODE:   count_mode   <= cfg.data[0];
        REG_FILE_MODE:    file_mode    <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign pat.pattern     = {pattern_high, pattern_low};
  assign pat.len         = pattern_len;
  assign pat.ignore_case = ignore_case;

  // result side
  assign take = result.valid && result.ready;

  always_comb begin
    b_line_left  = b_line;
    b_count_left = b_count;
    b_final_left = b_final;
    if (take) begin
      if (b_line) begin
        b_line_left = 1'b0;
      end else if (b_count) begin
        b_count_left = 1'b0;
      end else begin
        b_final_left = 1'b0;
      end
    end
    bund_free = !(b_line_left || b_count_left || b_final_left);
  end

  // item decode
  always_comb begin
    is_nl      = (s1_byte == NEWLINE);
    sel        = (wstat.empty_pat || line_hit) != invert_sense;
    closing    = s1_func ? (!stopped && line_pending) : (!stopped && is_nl);
    total_next = (closing && sel && sel_total != CNT_MAX) ? sel_total + 32'd1 : sel_total;
    n_line      = closing && (file_mode ? sel : !count_mode);
    n_line_file = file_mode;
    n_count     = s1_func && !stopped && count_mode && !(closing && file_mode && sel);
    n_final     = (s1_func && !stopped) || (!s1_func && closing && file_mode && sel);
    any_res     = s1_valid && (n_line || n_count || n_final);
    adv         = s1_valid && (!any_res || bund_free);
  end

  assign text.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready && text.valid) begin
      s1_func <= text.func;
      s1_byte <= text.data_byte;
    end
  end

  assign wctrl.shift   = adv && !s1_func && !stopped && !is_nl;
  assign wctrl.restart = adv && (s1_func || (!stopped && is_nl));
  assign wctrl.data    = s1_byte;

  fslm_window u_window (
    .clk  (clk),
    .rst  (rst),
    .pat  (pat),
    .ctrl (wctrl),
    .stat (wstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      line_hit     <= 1'b0;
      line_pending <= 1'b0;
      line_index   <= '0;
      sel_total    <= '0;
      stopped      <= 1'b0;
    end else if (adv) begin
      if (s1_func) begin
        line_hit     <= 1'b0;
        line_pending <= 1'b0;
        line_index   <= '0;
        sel_total    <= '0;
        stopped      <= 1'b0;
      end else if (!stopped) begin
        if (is_nl) begin
          line_hit     <= 1'b0;
          line_pending <= 1'b0;
          line_index   <= (line_index != CNT_MAX) ? line_index + 32'd1 : line_index;
          sel_total    <= total_next;
          stopped      <= file_mode && sel;
        end else begin
          line_pending <= 1'b1;
          line_hit     <= line_hit || wstat.hit;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_line  <= 1'b0;
      b_count <= 1'b0;
      b_final <= 1'b0;
    end else if (adv && any_res) begin
      b_line  <= n_line;
      b_count <= n_count;
      b_final <= n_final;
    end else begin
      b_line  <= b_line_left;
      b_count <= b_count_left;
      b_final <= b_final_left;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && any_res) begin
      b_line_file <= n_line_file;
      b_sel       <= sel;
      b_line_num  <= line_index;
      b_total     <= total_next;
    end
  end

  always_comb begin
    result.valid     = b_line || b_count || b_final;
    result.sel_count = b_total;
    result.status    = (b_total == '0);
    if (b_line) begin
      result.kind        = b_line_file ? KIND_FILE : KIND_VERDICT;
      result.selected    = b_sel;
      result.line_number = b_line_num;
      result.last        = !b_count && !b_final;
    end else if (b_count) begin
      result.kind        = KIND_COUNT;
      result.selected    = 1'b0;
      result.line_number = '0;
      result.last        = !b_final;
    end else begin
      result.kind        = KIND_FINAL;
      result.selected    = 1'b0;
      result.line_number = '0;
      result.last        = 1'b1;
    end
  end

endmodule

/* rtl/core/fslm_window.sv */
// Sliding byte window and parallel pattern compare for the line matcher.
// Depends on fslm_pkg.
`timescale 1ns / 1ps

module fslm_window (
  input  logic                    clk,
  input  logic                    rst,
  input  fslm_pkg::fslm_pat_t     pat,
  input  fslm_pkg::fslm_win_ctrl_t ctrl,
  output fslm_pkg::fslm_win_stat_t stat
);
  import fslm_pkg::*;

  logic [7:0]        window [WIN_DEPTH];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_inc;
  logic [FILL_W-1:0] plen;
  logic [7:0]        pat_bytes [PAT_REG_BYTES];
  logic [7:0]        cand [LEN_CAP];
  logic              eq;

  always_comb begin
    for (int i = 0; i < PAT_REG_BYTES; i++) begin
      pat_bytes[i] = pat.pattern[8*i +: 8];
    end
    plen = (32'(pat.len) > LEN_CAP) ? FILL_W'(LEN_CAP) : FILL_W'(pat.len);
    fill_inc = (32'(fill) < MAX_PATTERN) ? fill + FILL_W'(1) : fill;
  end

  // newest byte first; the incoming byte sits at position 0
  always_comb begin
    for (int k = 0; k < LEN_CAP; k++) begin
      cand[k] = (k == 0) ? ctrl.data : window[(k == 0) ? 0 : k - 1];
    end
    eq = 1'b1;
    for (int k = 0; k < LEN_CAP; k++) begin
      if (k < 32'(plen)) begin
        if (fold_byte(cand[k], pat.ignore_case) !=
            fold_byte(pat_bytes[PAT_IDX_W'(32'(plen) - 1 - k)], pat.ignore_case)) begin
          eq = 1'b0;
        end
      end
    end
  end

  assign stat.empty_pat = (plen == '0);
  assign stat.hit       = !stat.empty_pat && (fill_inc >= plen) && eq;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      window[0] <= ctrl.data;
      for (int k = 1; k < WIN_DEPTH; k++) begin
        window[k] <= window[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctrl.restart) begin
      fill <= '0;
    end else if (ctrl.shift) begin
      fill <= fill_inc;
    end
  end

endmodule

/* rtl/core/fslm_checker.sv */
// Port-level checks for the fixed-string line matcher, bound to the top level.
// Depends on fslm_pkg and fixed_string_line_matcher_macros.svh.
`timescale 1ns / 1ps
`include "fixed_string_line_matcher_macros.svh"

module fslm_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [1:0]  kind,
  input logic        selected,
  input logic [31:0] line_number,
  input logic [31:0] sel_count,
  input logic        status,
  input logic        last
);
  import fslm_pkg::*;

  `FSLM_ASSERT_NEXT(a_stall_hold, valid && !ready, valid && $stable(kind) && $stable(selected) && $stable(line_number) && $stable(sel_count) && $stable(last), "stalled result changed")
  `FSLM_ASSERT_SAME(a_final_last, valid && kind == KIND_FINAL, last, "final status not last")
  `FSLM_ASSERT_SAME(a_count_not_last, valid && kind == KIND_COUNT, !last, "count report marked last")
  `FSLM_ASSERT_SAME(a_file_not_last, valid && kind == KIND_FILE, !last && selected, "file report malformed")
  `FSLM_ASSERT_SAME(a_status, valid, status == (sel_count == 32'd0), "status disagrees with count")

endmodule

bind fixed_string_line_matcher fslm_checker u_fslm_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (result.valid),
  .ready       (result.ready),
  .kind        (result.kind),
  .selected    (result.selected),
  .line_number (result.line_number),
  .sel_count   (result.sel_count),
  .status      (result.status),
  .last        (result.last)
);

/* sim/tb_top.sv */
// Testbench for fixed_string_line_matcher: directed and random text streams against a
// built-in line matcher predictor, with random idles and stalls on both channels.
// Depends on fslm_pkg, fslm_text_if, fslm_result_if, fslm_cfg_if and the block itself.
`timescale 1ns / 1ps

module tb_top;
  import fslm_pkg::*;

  typedef struct packed {
    fslm_kind_t  kind;
    logic        selected;
    logic [31:0] line_number;
    logic [31:0] sel_count;
    logic        status;
    logic        last;
  } line_result_t;

  localparam int RANDOM_ITEMS = 260;
  localparam int HOLD_CYCLES  = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fslm_text_if   text_ch ();
  fslm_result_if res_ch ();
  fslm_cfg_if    cfg_ch ();

  fixed_string_line_matcher u_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always #6 clk = ~clk;

  line_result_t results_due[$];
  line_result_t step_out[$];
  int errors = 0;
  int taken_items = 0;
  bit calm = 1'b0;
  int hold_trig = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // shadow registers
  logic [63:0] pat_lo, pat_hi;
  logic [4:0]  pat_len;
  bit fold_en, invert_en, count_en, file_en;

  // predicted stream state
  logic [7:0]  win_q [WIN_DEPTH];
  int          win_fill;
  bit          line_hit, line_open, halted;
  logic [31:0] line_idx, sel_total;

  function automatic int pattern_span();
    int n;
    n = int'(pat_len);
    if (n > LEN_CAP) n = LEN_CAP;
    return n;
  endfunction

  function automatic logic [7:0] pattern_byte(int k);
    if (k < 8) return pat_lo[8*k +: 8];
    return pat_hi[8*(k-8) +: 8];
  endfunction

  function automatic logic [7:0] fold_ch(logic [7:0] b);
    if (fold_en && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) return b + FOLD_OFFSET;
    return b;
  endfunction

  function automatic void reset_stream();
    for (int k = 0; k < WIN_DEPTH; k++) win_q[k] = 8'h00;
    win_fill = 0;
    line_hit = 1'b0;
    line_open = 1'b0;
    line_idx = '0;
    sel_total = '0;
    halted = 1'b0;
  endfunction

  function automatic void add_result(fslm_kind_t k, bit sel, logic [31:0] num);
    line_result_t r;
    r.kind = k;
    r.selected = sel;
    r.line_number = num;
    r.sel_count = sel_total;
    r.status = (sel_total == 0);
    r.last = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void shift_in(logic [7:0] b);
    int plen;
    bit eq;
    plen = pattern_span();
    eq = 1'b1;
    for (int k = WIN_DEPTH - 1; k > 0; k--) win_q[k] = win_q[k-1];
    win_q[0] = b;
    if (win_fill < WIN_DEPTH) win_fill++;
    line_open = 1'b1;
    if (plen == 0 || win_fill < plen) return;
    for (int k = 0; k < plen; k++)
      if (fold_ch(win_q[k]) != fold_ch(pattern_byte(plen - 1 - k))) eq = 1'b0;
    if (eq) line_hit = 1'b1;
  endfunction

  function automatic bit close_line();
    bit sel;
    logic [31:0] num;
    sel = ((pattern_span() == 0) || line_hit) != invert_en;
    num = line_idx;
    if (sel && sel_total != CNT_MAX) sel_total++;
    if (line_idx != CNT_MAX) line_idx++;
    win_fill = 0;
    line_hit = 1'b0;
    line_open = 1'b0;
    if (file_en) begin
      if (sel) begin
        add_result(KIND_FILE, 1'b1, num);
        halted = 1'b1;
        return 1'b1;
      end
    end else if (!count_en) begin
      add_result(KIND_VERDICT, sel, num);
    end
    return 1'b0;
  endfunction

  function automatic void predict_request(bit is_end, logic [7:0] b);
    bit reported;
    line_result_t r;
    reported = 1'b0;
    step_out.delete();
    if (is_end) begin
      if (!halted) begin
        if (line_open) reported = close_line();
        if (count_en && !reported) add_result(KIND_COUNT, 1'b0, '0);
        add_result(KIND_FINAL, 1'b0, '0);
      end
      reset_stream();
    end else if (!halted) begin
      if (b == NEWLINE) begin
        reported = close_line();
        if (reported) add_result(KIND_FINAL, 1'b0, '0);
      end else begin
        shift_in(b);
      end
    end
    if (step_out.size() > 0) begin
      r = step_out[step_out.size() - 1];
      r.last = 1'b1;
      step_out[step_out.size() - 1] = r;
    end
    foreach (step_out[i]) results_due.push_back(step_out[i]);
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endfunction

  // result side: compare, then drive ready with random stalls or a long hold-off
  always @(posedge clk) begin : result_sink
    line_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: kind %0d line %0d", res_ch.kind, res_ch.line_number);
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("kind", 32'(want.kind), 32'(res_ch.kind));
        check_field("selected", 32'(want.selected), 32'(res_ch.selected));
        check_field("line_number", want.line_number, res_ch.line_number);
        check_field("sel_count", want.sel_count, res_ch.sel_count);
        check_field("status", 32'(want.status), 32'(res_ch.status));
        check_field("last", 32'(want.last), 32'(res_ch.last));
      end
    end
    if (hold_seen != hold_trig) begin
      hold_seen = hold_trig;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= calm || ($urandom_range(0, 99) >= 28);
    end
  end

  task automatic send_request(bit is_end, logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 28) begin
      text_ch.valid <= 1'b0;
      @(posedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.func <= is_end;
    text_ch.data_byte <= b;
    do @(posedge clk); while (!text_ch.ready);
    if (!halted) taken_items++;
    predict_request(is_end, b);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_request(1'b0, s[i]);
  endtask

  task automatic wait_drain();
    text_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(fslm_reg_t idx, logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_PATTERN_LOW:  pat_lo = val;
      REG_PATTERN_HIGH: pat_hi = val;
      REG_PATTERN_LEN:  pat_len = val[4:0];
      REG_IGNORE_CASE:  fold_en = val[0];
      REG_INVERT_SENSE: invert_en = val[0];
      REG_COUNT_MODE:   count_en = val[0];
      REG_FILE_MODE:    file_en = val[0];
      default: ;
    endcase
  endtask

  // block must be idle
  task automatic set_config(logic [63:0] lo, logic [63:0] hi, logic [4:0] len,
                            bit ic, bit inv, bit cnt, bit fm);
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_PATTERN_LEN, {59'd0, len});
    write_reg(REG_IGNORE_CASE, {63'd0, ic});
    write_reg(REG_INVERT_SENSE, {63'd0, inv});
    write_reg(REG_COUNT_MODE, {63'd0, cnt});
    write_reg(REG_FILE_MODE, {63'd0, fm});
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      case ($urandom_range(0, 3))
        0: return 8'h61;
        1: return 8'h62;
        2: return 8'h41;
        default: return 8'h42;
      endcase
    end
    if (r < 85) begin
      // letters at the ends of both cases and their neighbors
      case ($urandom_range(0, 7))
        0: return CHAR_UPPER_A - 8'd1;
        1: return CHAR_UPPER_A;
        2: return CHAR_UPPER_Z;
        3: return CHAR_UPPER_Z + 8'd1;
        4: return CHAR_UPPER_A + FOLD_OFFSET - 8'd1;
        5: return CHAR_UPPER_A + FOLD_OFFSET;
        6: return CHAR_UPPER_Z + FOLD_OFFSET;
        default: return CHAR_UPPER_Z + FOLD_OFFSET + 8'd1;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] vary_case(logic [7:0] b);
    if ($urandom_range(0, 1) == 0) return b;
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) return b + FOLD_OFFSET;
    if (b >= CHAR_UPPER_A + FOLD_OFFSET && b <= CHAR_UPPER_Z + FOLD_OFFSET)
      return b - FOLD_OFFSET;
    return b;
  endfunction

  task automatic random_phase(int phase_no);
    logic [63:0] lo, hi;
    logic [4:0]  len;
    bit ic, inv, cnt, fm;
    int n_lines, line_len, plen, at, cut, r;
    logic [7:0] line_q[$];
    for (int k = 0; k < 8; k++) begin
      lo[8*k +: 8] = pick_text_byte();
      hi[8*k +: 8] = pick_text_byte();
    end
    case ($urandom_range(0, 9))
      0: len = 5'd0;
      1, 2, 3, 4, 5: len = 5'($urandom_range(1, 4));
      6, 7: len = 5'($urandom_range(5, 16));
      8: len = 5'd16;
      default: len = 5'($urandom_range(17, 31));
    endcase
    ic = 1'($urandom_range(0, 1));
    inv = ($urandom_range(0, 3) == 0);
    cnt = ($urandom_range(0, 99) < 30);
    fm = ($urandom_range(0, 99) < 25);
    if (phase_no == 0) begin
      lo = '0;
      hi = '0;
      len = 5'($urandom_range(1, 16));
    end
    if (phase_no == 1) begin
      lo = '1;
      hi = '1;
      len = 5'd16;
    end
    if (phase_no == 2) len = 5'd31;
    calm = (phase_no == 3);
    set_config(lo, hi, len, ic, inv, cnt, fm);
    plen = pattern_span();
    n_lines = $urandom_range(0, 10);
    if (calm) n_lines = 10;
    for (int ln = 0; ln < n_lines; ln++) begin
      line_q.delete();
      line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      for (int j = 0; j < line_len; j++) line_q.push_back(pick_text_byte());
      r = $urandom_range(0, 99);
      cut = (r < 50) ? plen : (r < 65 && plen > 0) ? plen - 1 : 0;
      at = $urandom_range(0, line_q.size());
      for (int k = 0; k < cut; k++)
        line_q.insert(at + k, fold_en ? vary_case(pattern_byte(k)) : pattern_byte(k));
      foreach (line_q[j]) send_request(1'b0, line_q[j]);
      if (ln != n_lines - 1 || $urandom_range(0, 3) != 0) send_request(1'b0, NEWLINE);
    end
    send_request(1'b1, 8'($urandom_range(0, 255)));
    wait_drain();
    calm = 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_text("\nz");
    send_request(1'b1, 8'h00);
    send_text("\n");
    send_request(1'b1, 8'hff);
    wait_drain();
  endtask

  task automatic test_extreme_bytes_and_case();
    set_config(64'h00ff, '0, 5'd2, 1'b1, 1'b0, 1'b0, 1'b0);
    send_request(1'b0, 8'hff);
    send_request(1'b0, 8'h00);
    send_text("\n");
    wait_drain();
    set_config(64'h5a61, '1, 5'd2, 1'b1, 1'b0, 1'b0, 1'b0);
    send_text("Az\n");
    wait_drain();
    set_config(64'h5a61, '0, 5'd2, 1'b0, 1'b1, 1'b0, 1'b0);
    send_text("Az\n");
    send_request(1'b1, 8'h00);
    wait_drain();
  endtask

  task automatic test_file_over_count();
    set_config(64'h5a61, '0, 5'd2, 1'b1, 1'b0, 1'b1, 1'b1);
    send_text("xaZ\nq");
    send_request(1'b1, 8'h00);
    send_text("az");
    send_request(1'b1, 8'h00);
    wait_drain();
  endtask

  task automatic test_count_report();
    set_config(64'h5a61, '0, 5'd2, 1'b0, 1'b0, 1'b1, 1'b0);
    send_text("aZ\nb\nb");
    send_request(1'b1, 8'h00);
    wait_drain();
  endtask

  task automatic test_backpressure();
    set_config(64'h61, '0, 5'd1, 1'b0, 1'b0, 1'b0, 1'b0);
    hold_trig++;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 0) send_text("\n");
      else send_text("ba\n");
    end
    wait_drain();
    send_text("ba\nbb");
    send_request(1'b1, 8'h00);
    wait_drain();
  endtask

  task automatic test_random_streams();
    int phase_no;
    phase_no = 0;
    taken_items = 0;
    while (taken_items < RANDOM_ITEMS || phase_no < 4) begin
      random_phase(phase_no);
      phase_no++;
    end
  endtask

  initial begin
    text_ch.valid = 1'b0;
    text_ch.func = 1'b0;
    text_ch.data_byte = 8'h00;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_PATTERN_LOW;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    pat_lo = '0;
    pat_hi = '0;
    pat_len = '0;
    fold_en = 1'b0;
    invert_en = 1'b0;
    count_en = 1'b0;
    file_en = 1'b0;
    reset_stream();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_extreme_bytes_and_case();
    test_file_over_count();
    test_count_report();
    test_backpressure();
    test_random_streams();

    wait_drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* fixed_string_line_matcher.f */
+incdir+rtl/core
rtl/core/fslm_pkg.sv
rtl/core/fslm_text_if.sv
rtl/core/fslm_result_if.sv
rtl/core/fslm_cfg_if.sv
rtl/core/fslm_window.sv
rtl/core/fixed_string_line_matcher.sv
rtl/core/fslm_checker.sv
sim/tb_top.sv
